@@ hw/rtl/grid_neighbour_expansion_macros.svh @@
// ----------------------------------------------------------------------------
// Grid neighbour expansion: assertion macros
// Clocked implication checks used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef GRID_NEIGHBOUR_EXPANSION_MACROS_SVH
`define GRID_NEIGHBOUR_EXPANSION_MACROS_SVH

// same-cycle implication
`define GNE_ASSERT_IMP(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("gne: implication check failed");

// next-cycle implication
`define GNE_ASSERT_NXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("gne: next-cycle check failed");

`endif

@@ hw/rtl/gne_pkg.sv @@
// ----------------------------------------------------------------------------
// gne_pkg
// Types, constants and helper functions for the grid neighbour expansion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gne_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;

	// fixed field widths
	localparam int NODE_W    = 16;
	localparam int COST_W    = 4;
	localparam int CFG_W     = 9;
	localparam int REG_IDX_W = 2;

	// internal dimension widths
	localparam int DIM_MAX = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int DIM_W   = $clog2(DIM_MAX + 1);
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ROW_W   = $clog2(MAX_HEIGHT);
	localparam int CMP_W   = (2 * DIM_W > NODE_W) ? 2 * DIM_W : NODE_W + 1;

	// free map storage
	localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
	localparam int MEM_DEPTH  = (CELL_COUNT < (1 << NODE_W)) ? CELL_COUNT : (1 << NODE_W);
	localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// neighbour directions
	localparam int NUM_DIRS      = 8;
	localparam int STRAIGHT_DIRS = 4;
	localparam int DIR_W         = $clog2(NUM_DIRS);
	localparam int STEP_DX [NUM_DIRS] = '{1, -1, 0, 0, 1, 1, -1, -1};
	localparam int STEP_DY [NUM_DIRS] = '{0, 0, 1, -1, 1, -1, 1, -1};

	localparam logic [COST_W-1:0] COST_STRAIGHT = COST_W'(10);
	localparam logic [COST_W-1:0] COST_DIAG     = COST_W'(14);
	localparam logic [COST_W-1:0] STEP_COST [NUM_DIRS] = '{
		COST_STRAIGHT, COST_STRAIGHT, COST_STRAIGHT, COST_STRAIGHT,
		COST_DIAG, COST_DIAG, COST_DIAG, COST_DIAG
	};

	// centre cell plus every direction, then one slot to drain the read
	localparam int RD_SLOTS = NUM_DIRS + 1;
	localparam int RD_CNT_W = $clog2(RD_SLOTS + 1);
	localparam logic [RD_CNT_W-1:0] RD_LAST = RD_CNT_W'(RD_SLOTS);

	// operation codes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_EXPAND = 1'b1;

	// configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_GRID_WIDTH  = REG_IDX_W'(0);
	localparam logic [REG_IDX_W-1:0] REG_GRID_HEIGHT = REG_IDX_W'(1);
	localparam logic [REG_IDX_W-1:0] REG_DIAG_ENABLE = REG_IDX_W'(2);

	localparam logic [CFG_W-1:0] GRID_WIDTH_RST  = CFG_W'(256);
	localparam logic [CFG_W-1:0] GRID_HEIGHT_RST = CFG_W'(256);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_EMIT
	} gne_state_t;

	typedef struct packed {
		logic              done;
		logic [NODE_W-1:0] quot;
		logic [COL_W-1:0]  rem;
	} div_res_t;

	// 0 reads as 1, anything above the limit saturates
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int lim);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > lim) begin
			r = DIM_W'(lim);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	// linear index of the neighbour in direction dir
	function automatic logic [NODE_W-1:0] nb_addr(input logic [NODE_W-1:0] node,
			input logic [DIM_W-1:0] w, input logic [DIR_W-1:0] dir);
		logic [NODE_W-1:0] wn;
		logic [NODE_W-1:0] a;
		wn = NODE_W'(w);
		a  = node;
		if (STEP_DY[dir] == 1) begin
			a = a + wn;
		end else if (STEP_DY[dir] == -1) begin
			a = a - wn;
		end
		if (STEP_DX[dir] == 1) begin
			a = a + NODE_W'(1);
		end else if (STEP_DX[dir] == -1) begin
			a = a - NODE_W'(1);
		end
		return a;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/gne_cmd_if.sv @@
// ----------------------------------------------------------------------------
// gne_cmd_if
// Command channel: load a cell or expand a node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gne_cmd_if
	import gne_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [NODE_W-1:0] node_index;
	logic              cell_is_free;

	modport source(output valid, operation, node_index, cell_is_free, input ready);
	modport sink(input valid, operation, node_index, cell_is_free, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gne_rsp_if.sv @@
// ----------------------------------------------------------------------------
// gne_rsp_if
// Result channel: one neighbour per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gne_rsp_if
	import gne_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] neighbour_index;
	logic [COST_W-1:0] step_cost;
	logic              found;
	logic              last;

	modport source(output valid, neighbour_index, step_cost, found, last, input ready);
	modport sink(input valid, neighbour_index, step_cost, found, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gne_cfg_if.sv @@
// ----------------------------------------------------------------------------
// gne_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gne_cfg_if
	import gne_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [REG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/gne_div.sv @@
// ----------------------------------------------------------------------------
// gne_div
// Restoring divider, one quotient bit per cycle: node -> row, column.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gne_div
	import gne_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [NODE_W-1:0] dividend,
	input  wire logic [DIM_W-1:0]  divisor,
	output div_res_t               res
);

	localparam int CNT_W = $clog2(NODE_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [NODE_W-1:0] quot_q;
	logic [DIM_W-1:0]  rem_q;
	logic [DIM_W-1:0]  dsr_q;
	logic [DIM_W:0]    trial;
	logic              qbit;
	logic [DIM_W-1:0]  rem_nxt;

	// quot_q shifts the dividend out at the top and the quotient in at the bottom
	always_comb begin
		trial   = {rem_q, quot_q[NODE_W-1]};
		qbit    = (trial >= {1'b0, dsr_q});
		rem_nxt = qbit ? DIM_W'(trial - {1'b0, dsr_q}) : DIM_W'(trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NODE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dsr_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[NODE_W-2:0], qbit};
			rem_q  <= rem_nxt;
		end
	end

	assign res.done = done_q;
	assign res.quot = quot_q;
	assign res.rem  = COL_W'(rem_q);

endmodule

`default_nettype wire

@@ hw/rtl/grid_neighbour_expansion.sv @@
// Load: for a node inside the grid, the map bit is written at the accepting edge.
// Expand inside the grid: index division (16 quotient bits, then a done flag),
// serial map reads through one port (centre, each direction, a drain slot), then
// the results (1..8), lowest direction first, held back while the output stalls.
// Expand outside the grid: single not-found result; no command until it is loaded.
// Reset clears control and configuration (256 x 256, straight only), not the map.
// ----------------------------------------------------------------------------
// grid_neighbour_expansion
// Passability map with 4/8-neighbour expansion of a node.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "grid_neighbour_expansion_macros.svh"

module grid_neighbour_expansion
	import gne_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	gne_cmd_if.sink    cmd,
	gne_rsp_if.source  rsp,
	gne_cfg_if.sink    cfg
);

	gne_state_t state_q, state_nxt;

	logic [CFG_W-1:0]    width_q;
	logic [CFG_W-1:0]    height_q;
	logic                diag_q;
	logic [DIM_W-1:0]    eff_w;
	logic [DIM_W-1:0]    eff_h;
	logic [2*DIM_W-1:0]  total;
	logic                node_in_grid;

	logic                cmd_acc;
	logic                div_start;
	div_res_t            div_res;
	logic [NODE_W-1:0]   node_q;

	logic                mem [MEM_DEPTH];
	logic                map_we;
	logic                rd_issue;
	logic [NODE_W-1:0]   rd_addr;
	logic                rd_ok;
	logic                rd_bit_q;
	logic [RD_CNT_W-1:0] rd_cnt_q;
	logic                rd_vld_s1;
	logic [RD_CNT_W-1:0] rd_slot_s1;
	logic                rd_ok_s1;

	logic                center_q;
	logic [NUM_DIRS-1:0] mask_q;
	logic [NUM_DIRS-1:0] eff_mask;
	logic [DIR_W-1:0]    sel;
	logic [NUM_DIRS-1:0] sel_onehot;
	logic                slot_free;
	logic                emit_load;
	logic                emit_last;

	logic                rsp_valid_q;
	logic [NODE_W-1:0]   rsp_index_q;
	logic [COST_W-1:0]   rsp_cost_q;
	logic                rsp_found_q;
	logic                rsp_last_q;

	function automatic logic nb_ok(input logic [DIR_W-1:0] dir, input logic [COL_W-1:0] x,
			input logic [ROW_W-1:0] y, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h, input logic diag);
		logic ok;
		ok = 1'b1;
		if (STEP_DX[dir] == 1 && DIM_W'(x) == w - DIM_W'(1)) ok = 1'b0;
		if (STEP_DX[dir] == -1 && x == '0) ok = 1'b0;
		if (STEP_DY[dir] == 1 && DIM_W'(y) == h - DIM_W'(1)) ok = 1'b0;
		if (STEP_DY[dir] == -1 && y == '0) ok = 1'b0;
		if (32'(dir) >= STRAIGHT_DIRS && !diag) ok = 1'b0;
		return ok;
	endfunction

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= GRID_WIDTH_RST;
			height_q <= GRID_HEIGHT_RST;
			diag_q   <= 1'b0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_GRID_WIDTH:  width_q  <= cfg.data;
				REG_GRID_HEIGHT: height_q <= cfg.data;
				REG_DIAG_ENABLE: diag_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign eff_w        = clamp_dim(width_q, MAX_WIDTH);
	assign eff_h        = clamp_dim(height_q, MAX_HEIGHT);
	assign total        = (2*DIM_W)'(eff_w) * (2*DIM_W)'(eff_h);
	assign node_in_grid = CMP_W'(cmd.node_index) < CMP_W'(total);

	// ---------------- control ----------------
	assign cmd_acc = cmd.valid && cmd.ready;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_acc && cmd.operation == OP_EXPAND) begin
					state_nxt = node_in_grid ? ST_DIV : ST_EMIT;
				end
			end
			ST_DIV: begin
				if (div_res.done) state_nxt = ST_READ;
			end
			ST_READ: begin
				if (rd_cnt_q == RD_LAST) state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_load && emit_last) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == ST_IDLE);
		div_start = cmd_acc && cmd.operation == OP_EXPAND && node_in_grid;
		map_we    = cmd_acc && cmd.operation == OP_LOAD && node_in_grid;
		rd_issue  = (state_q == ST_READ) && (rd_cnt_q != RD_LAST);
		slot_free = !rsp_valid_q || rsp.ready;
		emit_load = (state_q == ST_EMIT) && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) node_q <= cmd.node_index;
	end

	gne_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (cmd.node_index),
		.divisor  (eff_w),
		.res      (div_res)
	);

	// ---------------- map reads: slot 0 is the centre, slot k is direction k-1
	always_comb begin
		if (rd_cnt_q == '0) begin
			rd_addr = node_q;
			rd_ok   = 1'b1;
		end else begin
			rd_addr = nb_addr(node_q, eff_w, DIR_W'(rd_cnt_q - RD_CNT_W'(1)));
			rd_ok   = nb_ok(DIR_W'(rd_cnt_q - RD_CNT_W'(1)), div_res.rem,
				div_res.quot[ROW_W-1:0], eff_w, eff_h, diag_q);
		end
	end

	always_ff @(posedge clk) begin
		if (map_we) mem[cmd.node_index[MEM_AW-1:0]] <= cmd.cell_is_free;
	end

	always_ff @(posedge clk) begin
		if (rd_issue) rd_bit_q <= mem[rd_addr[MEM_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_issue;
			if (state_q != ST_READ) begin
				rd_cnt_q <= '0;
			end else if (rd_cnt_q != RD_LAST) begin
				rd_cnt_q <= rd_cnt_q + RD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_slot_s1 <= rd_cnt_q;
		rd_ok_s1   <= rd_ok;
	end

	// ---------------- neighbour mask and result emission ----------------
	assign eff_mask = center_q ? mask_q : '0;

	always_comb begin
		sel = '0;
		for (int i = NUM_DIRS - 1; i >= 0; i--) begin
			if (eff_mask[i]) sel = DIR_W'(i);
		end
		sel_onehot = NUM_DIRS'(1) << sel;
		emit_last  = (eff_mask & ~sel_onehot) == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= 1'b0;
			mask_q   <= '0;
		end else begin
			if (cmd_acc && cmd.operation == OP_EXPAND) begin
				center_q <= 1'b0;
				mask_q   <= '0;
			end else if (rd_vld_s1) begin
				if (rd_slot_s1 == '0) begin
					center_q <= rd_bit_q;
				end else begin
					mask_q[DIR_W'(rd_slot_s1 - RD_CNT_W'(1))] <= rd_ok_s1 && rd_bit_q;
				end
			end else if (emit_load) begin
				mask_q <= mask_q & ~sel_onehot;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			if (eff_mask == '0) begin
				rsp_index_q <= '0;
				rsp_cost_q  <= '0;
				rsp_found_q <= 1'b0;
			end else begin
				rsp_index_q <= nb_addr(node_q, eff_w, sel);
				rsp_cost_q  <= STEP_COST[sel];
				rsp_found_q <= 1'b1;
			end
			rsp_last_q <= emit_last;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.neighbour_index = rsp_index_q;
	assign rsp.step_cost       = rsp_cost_q;
	assign rsp.found           = rsp_found_q;
	assign rsp.last            = rsp_last_q;

	// ---------------- checks ----------------
	`GNE_ASSERT_IMP(a_found_cost, clk, arst_n, rsp_valid_q && rsp_found_q, rsp_cost_q == COST_STRAIGHT || rsp_cost_q == COST_DIAG)
	`GNE_ASSERT_IMP(a_not_found_form, clk, arst_n, rsp_valid_q && !rsp_found_q, rsp_last_q && rsp_index_q == '0 && rsp_cost_q == '0)
	`GNE_ASSERT_NXT(a_div_to_read, clk, arst_n, state_q == ST_DIV && div_res.done, state_q == ST_READ)
	`GNE_ASSERT_IMP(a_no_diag_bits, clk, arst_n, state_q == ST_EMIT && !diag_q, mask_q[NUM_DIRS-1:STRAIGHT_DIRS] == '0)

endmodule

`default_nettype wire

@@ sim/tb_grid_neighbour_expansion.sv @@
// ----------------------------------------------------------------------------
// tb_grid_neighbour_expansion
// Self-checking bench for the grid neighbour expansion block. Cells are loaded
// through the command channel, then nodes are expanded and every result
// transaction is compared against a predicted neighbour list. The run walks
// through several grid shapes, including the register extremes, with random
// gaps on both channels and one long stall on the result side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_grid_neighbour_expansion;
	import gne_pkg::*;

	localparam int CELLS         = 65536;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int STALL_LIMIT   = 3000;
	localparam int RANDOM_ITEMS  = 12;
	localparam int WIN           = 4;

	// right, left, down, up, then the four diagonals
	localparam int NB_DX [8] = '{1, -1, 0, 0, 1, 1, -1, -1};
	localparam int NB_DY [8] = '{0, 0, 1, -1, 1, -1, 1, -1};
	localparam logic [COST_W-1:0] NB_COST [8] = '{
		4'd10, 4'd10, 4'd10, 4'd10, 4'd14, 4'd14, 4'd14, 4'd14
	};

	typedef struct packed {
		logic [NODE_W-1:0] neighbour_index;
		logic [COST_W-1:0] step_cost;
		logic              found;
		logic              last;
	} neighbour_t;

	class expansion_scoreboard;
		bit                cell_free [CELLS];
		bit                cell_written [CELLS];
		logic [CFG_W-1:0]  width_reg;
		logic [CFG_W-1:0]  height_reg;
		bit                diag_on;
		neighbour_t        expected [$];
		int                errors;
		int                loads;
		int                expansions;
		int                results;
		int                misses;

		function new();
			width_reg  = 9'd256;
			height_reg = 9'd256;
			diag_on    = 1'b0;
		endfunction

		function int eff_width();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH) return MAX_WIDTH;
			return int'(width_reg);
		endfunction

		function int eff_height();
			if (height_reg == 0) return 1;
			if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
			return int'(height_reg);
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			case (idx)
				REG_GRID_WIDTH: width_reg = data;
				REG_GRID_HEIGHT: height_reg = data;
				REG_DIAG_ENABLE: diag_on = data[0];
				default: ;
			endcase
		endfunction

		function bit cell_open(int x, int y, int w, int h);
			if (x < 0 || y < 0 || x >= w || y >= h) return 1'b0;
			return cell_free[y * w + x];
		endfunction

		// true when an expansion of node reads only loaded cells
		function bit safe_to_expand(int node);
			int w;
			int h;
			int x;
			int y;
			w = eff_width();
			h = eff_height();
			if (node >= w * h) return 1'b1;
			if (!cell_written[node]) return 1'b0;
			x = node % w;
			y = node / w;
			for (int i = 0; i < 8; i++) begin
				if (x + NB_DX[i] >= 0 && x + NB_DX[i] < w && y + NB_DY[i] >= 0
						&& y + NB_DY[i] < h
						&& !cell_written[(y + NB_DY[i]) * w + x + NB_DX[i]])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void note_command(logic op, logic [NODE_W-1:0] node, logic free_bit);
			int w;
			int h;
			int x;
			int y;
			int nx;
			int ny;
			int dirs;
			neighbour_t hits [$];
			neighbour_t r;
			w = eff_width();
			h = eff_height();
			if (op == OP_LOAD) begin
				loads++;
				if (int'(node) < w * h) begin
					cell_free[node]    = free_bit;
					cell_written[node] = 1'b1;
				end
				return;
			end
			expansions++;
			if (int'(node) < w * h) begin
				x = int'(node) % w;
				y = int'(node) / w;
				if (cell_free[node]) begin
					dirs = diag_on ? 8 : 4;
					for (int i = 0; i < dirs; i++) begin
						nx = x + NB_DX[i];
						ny = y + NB_DY[i];
						if (cell_open(nx, ny, w, h)) begin
							r.neighbour_index = NODE_W'(ny * w + nx);
							r.step_cost       = NB_COST[i];
							r.found           = 1'b1;
							r.last            = 1'b0;
							hits.push_back(r);
						end
					end
				end
			end
			if (hits.size() == 0) begin
				r      = '0;
				r.last = 1'b1;
				misses++;
			end else begin
				r      = hits.pop_back();
				r.last = 1'b1;
			end
			hits.push_back(r);
			foreach (hits[i]) expected.push_back(hits[i]);
		endfunction

		function void check_result(logic [NODE_W-1:0] idx, logic [COST_W-1:0] cost,
				logic fnd, logic lst);
			neighbour_t want;
			if (expected.size() == 0) begin
				errors++;
				$error("result transaction with nothing expected: neighbour_index %0d found %0b",
					idx, fnd);
				return;
			end
			want = expected.pop_front();
			results++;
			if (idx !== want.neighbour_index) begin
				errors++;
				$error("neighbour_index mismatch: expected %0d, actual %0d",
					want.neighbour_index, idx);
			end
			if (cost !== want.step_cost) begin
				errors++;
				$error("step_cost mismatch: expected %0d, actual %0d", want.step_cost, cost);
			end
			if (fnd !== want.found) begin
				errors++;
				$error("found mismatch: expected %0b, actual %0b", want.found, fnd);
			end
			if (lst !== want.last) begin
				errors++;
				$error("last mismatch: expected %0b, actual %0b", want.last, lst);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	gne_cmd_if cmd_ch();
	gne_rsp_if rsp_ch();
	gne_cfg_if cfg_ch();

	grid_neighbour_expansion uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	expansion_scoreboard sb = new();

	bit hold_results = 1'b0;
	int holds_done   = 0;
	int items_sent   = 0;
	int cmd_calm     = 0;
	int stalled      = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_result(rsp_ch.neighbour_index, rsp_ch.step_cost, rsp_ch.found,
				rsp_ch.last);
	end

	// watchdog: cycles with no transaction on any channel
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			stalled = 0;
		end else begin
			stalled++;
		end
		if (stalled >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// mostly random gaps, with occasional runs of back-to-back transactions
	function automatic int draw_gap(ref int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 30);
			return 0;
		end
		return $urandom_range(0, 15);
	endfunction

	// result side
	initial begin
		int gap;
		int calm;
		calm = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_results) begin
				gap          = HOLD_CYCLES;
				hold_results = 1'b0;
				holds_done++;
			end else begin
				gap = draw_gap(calm);
			end
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	task automatic send_cmd(input logic op, input int node, input logic free_bit);
		int gap;
		gap = draw_gap(cmd_calm);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.operation    <= op;
		cmd_ch.node_index   <= NODE_W'(node);
		cmd_ch.cell_is_free <= free_bit;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.note_command(op, NODE_W'(node), free_bit);
		items_sent++;
	endtask

	task automatic write_register(input logic [REG_IDX_W-1:0] idx, input int value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= CFG_W'(value);
		do @(posedge clk); while (!cfg_ch.ready);
		sb.set_register(idx, CFG_W'(value));
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	// loads give no result, so allow the block to settle after the last one
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int w_reg, input int h_reg, input bit diag);
		wait_drained();
		write_register(REG_GRID_WIDTH, w_reg);
		write_register(REG_GRID_HEIGHT, h_reg);
		write_register(REG_DIAG_ENABLE, diag);
	endtask

	// 3 x 3 grid, all cells free, then blocked centre and out-of-grid nodes
	task automatic directed_checks();
		configure(3, 3, 1'b1);
		for (int i = 0; i < 9; i++) send_cmd(OP_LOAD, i, 1'b1);
		send_cmd(OP_EXPAND, 4, 1'b0);
		send_cmd(OP_EXPAND, 0, 1'b1);
		send_cmd(OP_EXPAND, 8, 1'b0);
		send_cmd(OP_EXPAND, 9, 1'b1);
		send_cmd(OP_EXPAND, 65535, 1'b0);
		send_cmd(OP_LOAD, 65535, 1'b1);
		send_cmd(OP_LOAD, 4, 1'b0);
		send_cmd(OP_EXPAND, 4, 1'b1);
		send_cmd(OP_EXPAND, 1, 1'b0);
		send_cmd(OP_LOAD, 4, 1'b1);
	endtask

	// pressure: 1 stalls the result side for a long stretch,
	// 2 pauses the command side halfway until all results are back
	task automatic run_phase(input int w_reg, input int h_reg, input bit diag,
			input int n_rand, input int pressure);
		int w;
		int h;
		int total;
		int cw;
		int ch;
		int c0;
		int r0;
		int node;
		int pick;
		configure(w_reg, h_reg, diag);
		w     = sb.eff_width();
		h     = sb.eff_height();
		total = w * h;
		cw    = (w < WIN) ? w : WIN;
		ch    = (h < WIN) ? h : WIN;
		case ($urandom_range(0, 2))
			0: c0 = 0;
			1: c0 = w - cw;
			default: c0 = $urandom_range(0, w - cw);
		endcase
		case ($urandom_range(0, 2))
			0: r0 = 0;
			1: r0 = h - ch;
			default: r0 = $urandom_range(0, h - ch);
		endcase
		for (int y = r0; y < r0 + ch; y++)
			for (int x = c0; x < c0 + cw; x++)
				send_cmd(OP_LOAD, y * w + x, $urandom_range(0, 3) != 0);
		if (pressure == 1) hold_results = 1'b1;
		for (int i = 0; i < n_rand; i++) begin
			if (pressure == 2 && i == n_rand / 2) wait_drained();
			pick = $urandom_range(0, 99);
			node = $urandom_range(r0, r0 + ch - 1) * w + $urandom_range(c0, c0 + cw - 1);
			if (pick < 60) begin
				if (sb.safe_to_expand(node))
					send_cmd(OP_EXPAND, node, $urandom_range(0, 1));
				else if (total < CELLS)
					send_cmd(OP_EXPAND, $urandom_range(65535, total), $urandom_range(0, 1));
				else
					send_cmd(OP_LOAD, node, $urandom_range(0, 3) != 0);
			end else if (pick < 80) begin
				send_cmd(OP_LOAD, node, $urandom_range(0, 1));
			end else if (pick < 88) begin
				send_cmd(OP_LOAD, $urandom_range(0, 65535), $urandom_range(0, 1));
			end else begin
				if (pick >= 96) node = $urandom_range(0, 65535);
				else if (total < CELLS) node = $urandom_range(65535, total);
				if (sb.safe_to_expand(node))
					send_cmd(OP_EXPAND, node, $urandom_range(0, 1));
				else
					send_cmd(OP_LOAD, node, $urandom_range(0, 1));
			end
		end
	endtask

	initial begin
		int ph_w [12];
		int ph_h [12];
		bit ph_d [12];
		int ph_p [12];
		ph_w = '{256, 256, 511, 0, 1, 2, 1, 256, 5, 3, 300, 17};
		ph_h = '{256, 256, 300, 0, 1, 2, 256, 1, 7, 4, 2, 9};
		ph_d = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
		ph_p = '{0, 1, 0, 0, 0, 0, 0, 0, 2, 0, 0, 0};
		cmd_ch.valid        <= 1'b0;
		cmd_ch.operation    <= OP_LOAD;
		cmd_ch.node_index   <= '0;
		cmd_ch.cell_is_free <= 1'b0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= REG_GRID_WIDTH;
		cfg_ch.data         <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_checks();
		for (int p = 0; p < 12; p++)
			run_phase(ph_w[p], ph_h[p], ph_d[p], RANDOM_ITEMS, ph_p[p]);
		for (int p = 0; p < 4; p++)
			run_phase($urandom_range(1, 24), $urandom_range(1, 24), $urandom_range(0, 1),
				RANDOM_ITEMS, 0);
		run_phase($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 1),
			RANDOM_ITEMS, 0);
		wait_drained();

		$display("summary: %0d commands (%0d loads, %0d expansions) over 18 grid settings",
			items_sent, sb.loads, sb.expansions);
		$display("summary: %0d result transactions checked, %0d not-found, %0d long stalls",
			sb.results, sb.misses, holds_done);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
